@@ hw/rtl/pts_pkg.sv @@
// shared types and constants for the point-to-screen projection pipeline
// used by pts_div and project_point_to_screen_top; no dependencies
package pts_pkg;

    localparam int NUM_REGS  = 8;
    localparam int ADDR_W    = 6;
    localparam int REG_W     = 64;
    localparam int Q_W       = 32;
    // one quotient bit per divider step
    localparam int DIV_STEPS = 32;
    // scale multiply, numerator build, overflow check, steps, output
    localparam int DIV_LAT   = DIV_STEPS + 4;
    // product, row sum, magnitude prep
    localparam int PRE_LAT   = 3;
    localparam int TOTAL_LAT = PRE_LAT + DIV_LAT;

    localparam logic [Q_W-1:0] Q16_MAX = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] Q16_MIN = 32'h8000_0000;

    typedef logic [REG_W-1:0] cfg_word_t;

    // identity matrix after reset
    localparam cfg_word_t MAT_RESET [NUM_REGS] = '{
        64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
        64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
    };

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        logic signed [31:0] depth;
        logic               w_was_zero;
    } screen_t;

    // sign and zero-w flags that travel beside the divider data
    typedef struct packed {
        logic neg;
        logic zero;
    } pts_side_t;

endpackage

@@ hw/rtl/pts_div.sv @@
// one lane of the scaled divide: (ms * SCALE * 2^16 + mw) / (2 * mw), rounded
// and saturated to signed Q16.16; depends on pts_pkg
module pts_div
    import pts_pkg::*;
#(
    parameter int SCALE = 1
)
(
    input  logic            clk,
    input  logic            en,
    input  logic [63:0]     ms,
    input  logic [63:0]     mw,
    input  pts_side_t       side,
    output logic [Q_W-1:0]  result,
    output logic            zero_out
);

    localparam int SW = $clog2(SCALE + 1);
    localparam logic [SW-1:0] SCALE_K = SW'(SCALE);

    logic [31+SW:0]  plo_reg, phi_reg;
    logic [63:0]     mw_d1_reg;
    pts_side_t       side_d1_reg, side_d2_reg;
    logic [95:0]     prod_next, n_next, n_reg;
    logic [63:0]     d_reg;

    logic [63:0]     rem_reg  [DIV_STEPS+1];
    logic [31:0]     low_reg  [DIV_STEPS+1];
    logic [31:0]     q_reg    [DIV_STEPS+1];
    logic [63:0]     dv_reg   [DIV_STEPS+1];
    logic            ovf_reg  [DIV_STEPS+1];
    pts_side_t       sd_reg   [DIV_STEPS+1];

    logic [Q_W-1:0]  result_next, result_reg;
    logic            zero_reg;
    logic [31:0]     qf;
    logic            big;

    // split the magnitude so each product stays narrow
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plo_reg     <= {{SW{1'b0}}, ms[31:0]} * {32'b0, SCALE_K};
            phi_reg     <= {{SW{1'b0}}, ms[63:32]} * {32'b0, SCALE_K};
            mw_d1_reg   <= mw;
            side_d1_reg <= side;
        end
    end

    always_comb
    begin
        prod_next = 96'(plo_reg) + (96'(phi_reg) << 32);
        n_next    = (prod_next << 16) + 96'(mw_d1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg       <= n_next;
            d_reg       <= {mw_d1_reg[62:0], 1'b0};
            side_d2_reg <= side_d1_reg;
        end
    end

    // quotient reaches 2^32 when the upper part is not below the divisor
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= n_reg[95:32];
            low_reg[0] <= n_reg[31:0];
            q_reg[0]   <= '0;
            dv_reg[0]  <= d_reg;
            ovf_reg[0] <= (n_reg[95:32] >= d_reg);
            sd_reg[0]  <= side_d2_reg;
        end
    end

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++)
        begin : g_step
            logic [64:0] t;
            logic [64:0] diff;
            logic        ge;

            always_comb
            begin
                t    = {rem_reg[k], low_reg[k][31]};
                diff = t - {1'b0, dv_reg[k]};
                ge   = (t >= {1'b0, dv_reg[k]});
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1] <= ge ? diff[63:0] : t[63:0];
                    low_reg[k+1] <= {low_reg[k][30:0], 1'b0};
                    q_reg[k+1]   <= {q_reg[k][30:0], ge};
                    dv_reg[k+1]  <= dv_reg[k];
                    ovf_reg[k+1] <= ovf_reg[k];
                    sd_reg[k+1]  <= sd_reg[k];
                end
            end
        end
    endgenerate

    always_comb
    begin
        qf  = q_reg[DIV_STEPS];
        big = ovf_reg[DIV_STEPS] || qf[31];
        if (sd_reg[DIV_STEPS].zero)
            result_next = '0;
        else if (sd_reg[DIV_STEPS].neg)
            result_next = big ? Q16_MIN : 32'(-qf);
        else
            result_next = big ? Q16_MAX : qf;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
            zero_reg   <= sd_reg[DIV_STEPS].zero;
        end
    end

    assign result   = result_reg;
    assign zero_out = zero_reg;

endmodule

@@ hw/rtl/project_point_to_screen_top.sv @@
// point-to-screen projection: 4x4 matrix transform, perspective divide, viewport map
// depends on pts_pkg and pts_div
// pipeline from accepted point to screen result: 3 transform stages and 36 divider
// stages, of which 32 are one-bit restoring steps
// throughput: one point per cycle; the whole pipeline holds while the result is stalled
// reset: valid bits cleared, matrix registers return to identity
module project_point_to_screen_top
    import pts_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 768
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [REG_W-1:0]   pwdata,
    output logic [REG_W-1:0]   prdata,
    output logic               pready,
    input  logic               point_valid,
    output logic               point_stall,
    input  point_t             point,
    output logic               screen_valid,
    input  logic               screen_stall,
    output screen_t            screen
);

    cfg_word_t           cfg_reg [NUM_REGS];
    logic                adv;
    logic [TOTAL_LAT-1:0] valid_reg;

    logic signed [31:0]  mat      [4][4];
    logic signed [31:0]  pt       [3];
    logic signed [63:0]  prod_next[4][3];
    logic [61:0]         prod_reg [4][3];
    logic [63:0]         m3_reg   [4];
    logic [63:0]         clip_next[4];
    logic [63:0]         clip_reg [4];
    logic [63:0]         s_next   [3];
    logic [63:0]         ms_reg   [3];
    logic [63:0]         mw_reg;
    pts_side_t           side_reg [3];
    logic [Q_W-1:0]      res      [3];
    logic                zero_lane[3];

    // configuration port
    assign pready = 1'b1;
    assign prdata = cfg_reg[paddr[ADDR_W-1:3]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                cfg_reg[i] <= MAT_RESET[i];
        end
        else if (psel && penable && pwrite && pready)
        begin
            cfg_reg[paddr[ADDR_W-1:3]] <= pwdata;
        end
    end

    assign adv         = !(screen_valid && screen_stall);
    assign point_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[TOTAL_LAT-2:0], point_valid};
    end

    assign screen_valid = valid_reg[TOTAL_LAT-1];

    // stage 1: products, floored to Q32.30
    always_comb
    begin
        pt[0] = point.point_x;
        pt[1] = point.point_y;
        pt[2] = point.point_z;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
                mat[r][c] = cfg_reg[r*2 + c/2][(c%2)*32 +: 32];
            for (int c = 0; c < 3; c++)
                prod_next[r][c] = mat[r][c] * pt[c];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 3; c++)
                    prod_reg[r][c] <= prod_next[r][c][63:2];
                m3_reg[r] <= {{18{mat[r][3][31]}}, mat[r][3], 14'b0};
            end
        end
    end

    // stage 2: clip coordinates
    always_comb
    begin
        for (int r = 0; r < 4; r++)
            clip_next[r] = {{2{prod_reg[r][0][61]}}, prod_reg[r][0]}
                         + {{2{prod_reg[r][1][61]}}, prod_reg[r][1]}
                         + {{2{prod_reg[r][2][61]}}, prod_reg[r][2]}
                         + m3_reg[r];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 4; r++)
                clip_reg[r] <= clip_next[r];
        end
    end

    // stage 3: signs and magnitudes of (c + w) and w
    always_comb
    begin
        for (int r = 0; r < 3; r++)
            s_next[r] = clip_reg[r] + clip_reg[3];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                ms_reg[r]        <= s_next[r][63] ? 64'(-s_next[r]) : s_next[r];
                side_reg[r].neg  <= s_next[r][63] ^ clip_reg[3][63];
                side_reg[r].zero <= (clip_reg[3] == '0);
            end
            mw_reg <= clip_reg[3][63] ? 64'(-clip_reg[3]) : clip_reg[3];
        end
    end

    pts_div #(.SCALE(SCREEN_WIDTH)) u_div_x (
        .clk(clk), .en(adv), .ms(ms_reg[0]), .mw(mw_reg), .side(side_reg[0]),
        .result(res[0]), .zero_out(zero_lane[0])
    );

    pts_div #(.SCALE(SCREEN_HEIGHT)) u_div_y (
        .clk(clk), .en(adv), .ms(ms_reg[1]), .mw(mw_reg), .side(side_reg[1]),
        .result(res[1]), .zero_out(zero_lane[1])
    );

    pts_div #(.SCALE(1)) u_div_z (
        .clk(clk), .en(adv), .ms(ms_reg[2]), .mw(mw_reg), .side(side_reg[2]),
        .result(res[2]), .zero_out(zero_lane[2])
    );

    always_comb
    begin
        screen.screen_x   = res[0];
        screen.screen_y   = res[1];
        screen.depth      = res[2];
        screen.w_was_zero = zero_lane[0];
    end

    // all lanes see the same w
    a_zero_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
        screen_valid |-> (zero_lane[0] == zero_lane[1]) && (zero_lane[0] == zero_lane[2]))
        else $error("zero-w flag differs between lanes");

    a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
        screen_valid && screen.w_was_zero |->
            (screen.screen_x == 0) && (screen.screen_y == 0) && (screen.depth == 0))
        else $error("zero-w transaction with nonzero fields");

    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        point_stall |-> screen_valid && screen_stall)
        else $error("input stalled without output backpressure");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && !point_stall |=> valid_reg[0])
        else $error("accepted transaction not in first stage");

endmodule

@@ tb/tb_pts_checker.sv @@
// checker for project_point_to_screen_top: watches the point and screen channels,
// predicts each screen transaction from the current matrix, compares field by field
// depends on pts_pkg
`timescale 1ns / 1ps

module tb_pts_checker
    import pts_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 768
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  point_valid,
    input  logic                  point_stall,
    input  point_t                point,
    input  logic                  screen_valid,
    input  logic                  screen_stall,
    input  screen_t               screen,
    input  cfg_word_t             matrix [NUM_REGS],
    output int                    fail_count,
    output int                    pending_count
);

    screen_t expected_screens [$];

    function automatic logic signed [63:0] mat_at(int row, int col);
        cfg_word_t w;
        w = matrix[row * 2 + col / 2];
        return (col % 2) ? 64'(signed'(w[63:32])) : 64'(signed'(w[31:0]));
    endfunction

    // s * scale / (2w), rounded half away from zero, saturated to q16.16
    function automatic logic [31:0] viewport_ratio(logic signed [63:0] s,
                                                   logic signed [63:0] w,
                                                   int unsigned scale);
        logic         neg;
        logic [63:0]  ms;
        logic [63:0]  mw;
        logic [127:0] num;
        logic [127:0] quo;
        neg = (s < 0) != (w < 0);
        ms = (s < 0) ? -s : s;
        mw = (w < 0) ? -w : w;
        num = 128'(ms) * 128'(64'(scale) << 16) + 128'(mw);
        quo = num / (128'(mw) << 1);
        if (neg)
            return (quo >= 128'h8000_0000) ? Q16_MIN : 32'(-quo);
        return (quo > 128'h7FFF_FFFF) ? Q16_MAX : quo[31:0];
    endfunction

    function automatic screen_t project_point(point_t p);
        logic signed [63:0] pc [3];
        logic signed [63:0] clip [4];
        logic signed [63:0] acc;
        screen_t            r;
        pc[0] = 64'(p.point_x);
        pc[1] = 64'(p.point_y);
        pc[2] = 64'(p.point_z);
        for (int row = 0; row < 4; row++)
        begin
            acc = mat_at(row, 3) * 64'sd16384;
            for (int col = 0; col < 3; col++)
                acc += (mat_at(row, col) * pc[col]) >>> 2;
            clip[row] = acc;
        end
        r = '0;
        if (clip[3] == 0)
            r.w_was_zero = 1'b1;
        else
        begin
            r.screen_x = viewport_ratio(clip[0] + clip[3], clip[3], SCREEN_WIDTH);
            r.screen_y = viewport_ratio(clip[1] + clip[3], clip[3], SCREEN_HEIGHT);
            r.depth    = viewport_ratio(clip[2] + clip[3], clip[3], 1);
        end
        return r;
    endfunction

    assign pending_count = expected_screens.size();

    always @(posedge clk)
    begin
        screen_t want;
        if (rst_n)
        begin
            if (point_valid && !point_stall)
                expected_screens.push_back(project_point(point));
            if (screen_valid && !screen_stall)
            begin
                if (expected_screens.size() == 0)
                begin
                    $display("%0t: unexpected screen transaction %h", $time, screen);
                    fail_count++;
                end
                else
                begin
                    want = expected_screens.pop_front();
                    if (want.screen_x !== screen.screen_x)
                    begin
                        $display("%0t: screen_x expected %h actual %h",
                                 $time, want.screen_x, screen.screen_x);
                        fail_count++;
                    end
                    if (want.screen_y !== screen.screen_y)
                    begin
                        $display("%0t: screen_y expected %h actual %h",
                                 $time, want.screen_y, screen.screen_y);
                        fail_count++;
                    end
                    if (want.depth !== screen.depth)
                    begin
                        $display("%0t: depth expected %h actual %h",
                                 $time, want.depth, screen.depth);
                        fail_count++;
                    end
                    if (want.w_was_zero !== screen.w_was_zero)
                    begin
                        $display("%0t: w_was_zero expected %b actual %b",
                                 $time, want.w_was_zero, screen.w_was_zero);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial fail_count = 0;

endmodule

@@ tb/tb_project_point_to_screen_top.sv @@
// testbench top for project_point_to_screen_top: clock, reset, apb matrix writes,
// point stimulus and result stalls; checking lives in tb_pts_checker
// depends on pts_pkg, project_point_to_screen_top and tb_pts_checker
`timescale 1ns / 1ps

module tb_project_point_to_screen_top;
    import pts_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [REG_W-1:0]   pwdata;
    logic [REG_W-1:0]   prdata;
    logic               pready;
    logic               point_valid;
    logic               point_stall;
    point_t             point;
    logic               screen_valid;
    logic               screen_stall;
    screen_t            screen;
    cfg_word_t          matrix [NUM_REGS];
    int                 fail_count;
    int                 pending_count;
    logic               calm;

    project_point_to_screen_top dut (.*);

    tb_pts_checker checker_inst (
        .clk(clk), .rst_n(rst_n),
        .point_valid(point_valid), .point_stall(point_stall), .point(point),
        .screen_valid(screen_valid), .screen_stall(screen_stall), .screen(screen),
        .matrix(matrix), .fail_count(fail_count), .pending_count(pending_count)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(negedge clk)
        screen_stall <= (!calm && $urandom_range(99) < 20);

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'h8000_0000 + $urandom_range(1);
            2: return 32'h7FFF_FFFF - $urandom_range(1);
            default: return 32'($signed($urandom_range(20 << 16)) - (10 << 16));
        endcase
    endfunction

    task automatic write_matrix_reg(int idx, cfg_word_t value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx * 8);
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        matrix[idx] = value;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // valid stays high after a transaction so the next one can follow directly
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        while (!calm && $urandom_range(99) < 20)
        begin
            point_valid <= 1'b0;
            @(negedge clk);
        end
        point_valid <= 1'b1;
        point <= '{point_x: x, point_y: y, point_z: z};
        @(posedge clk);
        while (point_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_results();
        point_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (TOTAL_LAT + 5) @(posedge clk);
    endtask

    task automatic load_random_matrix(int style);
        logic [31:0] a;
        logic [31:0] b;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            case (style)
                0: write_matrix_reg(i, {$urandom(), $urandom()});
                1: write_matrix_reg(i, (i % 2) ? {32'h7FFF_FFFF, 32'h8000_0000}
                                               : {32'h8000_0000, 32'h7FFF_FFFF});
                default:
                begin
                    a = 32'($signed($urandom_range(4 << 16)) - (2 << 16));
                    b = 32'($signed($urandom_range(4 << 16)) - (2 << 16));
                    write_matrix_reg(i, {a, b});
                end
            endcase
        end
        // perspective-like last row keeps w away from zero most of the time
        if (style == 3)
        begin
            write_matrix_reg(6, 64'h0);
            write_matrix_reg(7, {32'h0001_0000, 32'hFFFF_0000});
        end
    endtask

    initial
    begin
        for (int i = 0; i < NUM_REGS; i++)
            matrix[i] = MAT_RESET[i];
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        point_valid = 1'b0;
        point = '0;
        screen_stall = 1'b0;
        calm = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // identity matrix: extremes, zero, w never zero here
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
        send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_AAAA);
        drain_results();

        // zero w: last row all zero
        write_matrix_reg(7, 64'h0);
        send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        drain_results();

        // w from z only: z = 0 gives zero w, tiny w saturates
        write_matrix_reg(6, {32'h0, 32'h0});
        write_matrix_reg(7, {32'h0, 32'h0001_0000});
        send_point(32'h0005_0000, 32'h0001_0000, 32'h0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        send_point(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000);
        send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000);
        drain_results();

        // extreme matrix entries
        load_random_matrix(1);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h0001_0000, 32'h0, 32'hFFFF_FFFF);
        drain_results();

        for (int phase = 0; phase < 8; phase++)
        begin
            load_random_matrix(phase % 4);
            calm = (phase == 5);
            for (int n = 0; n < 130; n++)
                send_point(rand_coord(), rand_coord(), rand_coord());
            drain_results();
        end
        calm = 1'b0;

        if (fail_count == 0)
            $display("** project_point_to_screen_top: PASSED **");
        else
            $display("** project_point_to_screen_top: FAILED **");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("** project_point_to_screen_top: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/pts_pkg.sv
hw/rtl/pts_div.sv
hw/rtl/project_point_to_screen_top.sv
tb/tb_pts_checker.sv
tb/tb_project_point_to_screen_top.sv
